@@ rtl/modular_exponentiation_top_macros.svh @@
// Assertion macros used by the modular exponentiation controller.
`ifndef MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MEX_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MEX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MEX_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MEX_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/mex_pkg.sv @@
package mex_pkg;

   localparam int EXP_BITS_DEF = 64;
   localparam int MOD_BITS_DEF = 32;

   localparam int BASE_W     = 64;
   localparam int EXP_W      = 63;
   localparam int RESULT_W   = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [31:0] RESET_MODULUS = 32'd1000000007;
   localparam logic [31:0] FERMAT_OFFSET = 32'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MODULUS = '0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_CHECK,
      S_MUL_ACC,
      S_START_SQ,
      S_MUL_SQ,
      S_FINISH
   } state_type;

   typedef enum logic {
      DEST_PW,
      DEST_ACC
   } dest_type;

   typedef struct packed {
      logic     load;
      logic     step;
      logic     reduce;
      dest_type dest;
      logic     start_mul;
      logic     src_acc;
      logic     shift_exp;
      logic     out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic step_last;
      logic exp_zero;
      logic exp_lsb;
      logic mod_zero;
   } dp_status_type;

endpackage

@@ rtl/mex_ctrl.sv @@
`include "modular_exponentiation_top_macros.svh"

module mex_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mex_pkg::dp_status_type status,
   output mex_pkg::dp_cmd_type    cmd
);
   import mex_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.dest = DEST_PW;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.step   = 1'b1;
            cmd.reduce = 1'b1;
            cmd.dest   = DEST_PW;
            if (status.step_last) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.mod_zero || status.exp_zero) begin
               state_in = S_FINISH;
            end else if (status.exp_lsb) begin
               cmd.start_mul = 1'b1;
               cmd.src_acc   = 1'b1;
               state_in      = S_MUL_ACC;
            end else begin
               cmd.start_mul = 1'b1;
               state_in      = S_MUL_SQ;
            end
         end
         S_MUL_ACC: begin
            cmd.step = 1'b1;
            cmd.dest = DEST_ACC;
            if (status.step_last) state_in = S_START_SQ;
         end
         S_START_SQ: begin
            cmd.start_mul = 1'b1;
            state_in      = S_MUL_SQ;
         end
         S_MUL_SQ: begin
            cmd.step = 1'b1;
            cmd.dest = DEST_PW;
            if (status.step_last) begin
               cmd.shift_exp = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != S_IDLE);

   `MEX_ASSERT_NEXT(a_reduce_exit, clock, reset, state_ff == S_REDUCE,
      state_ff == S_REDUCE || state_ff == S_CHECK)
   `MEX_ASSERT_NEXT(a_sq_hold, clock, reset, state_ff == S_MUL_SQ && !status.step_last,
      state_ff == S_MUL_SQ)
   `MEX_ASSERT_NEXT(a_finish_out, clock, reset,
      state_ff == S_FINISH && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == S_IDLE)
   `MEX_ASSERT_NEXT(a_check_done, clock, reset,
      state_ff == S_CHECK && (status.exp_zero || status.mod_zero), state_ff == S_FINISH)

endmodule

@@ rtl/mex_dpath.sv @@
module mex_dpath #(
   parameter int EXP_BITS = mex_pkg::EXP_BITS_DEF,
   parameter int MOD_BITS = mex_pkg::MOD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [MOD_BITS-1:0]           modulus,
   input  logic                          req_kind,
   input  logic [mex_pkg::BASE_W-1:0]    req_base,
   input  logic [mex_pkg::EXP_W-1:0]     req_exponent,
   input  mex_pkg::dp_cmd_type           cmd,
   output mex_pkg::dp_status_type        status,
   output logic [mex_pkg::RESULT_W-1:0]  rsp_result
);
   import mex_pkg::*;

   localparam int CNT_W = $clog2(BASE_W + 1);

   logic [BASE_W-1:0]   scan_ff, scan_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MOD_BITS-1:0] r_ff, r_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] pw_ff, pw_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [RESULT_W-1:0] result_ff, result_in;

   logic [MOD_BITS:0]   m_ext, dbl, dbl_red, addend, sum, sum_red;
   logic [MOD_BITS-1:0] r_next, mul_y;
   logic [BASE_W-1:0]   e_full;
   logic                last;

   assign m_ext   = {1'b0, modulus};
   assign dbl     = {r_ff, 1'b0};
   assign dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
   assign addend  = !scan_ff[BASE_W-1] ? '0 :
                    cmd.reduce ? (MOD_BITS+1)'(1) : {1'b0, pw_ff};
   assign sum     = {1'b0, dbl_red[MOD_BITS-1:0]} + addend;
   assign sum_red = (sum >= m_ext) ? sum - m_ext : sum;
   assign r_next  = sum_red[MOD_BITS-1:0];
   assign last    = (cnt_ff == CNT_W'(1));
   assign mul_y   = cmd.src_acc ? acc_ff : pw_ff;

   always_comb begin
      if (req_kind) begin
         if (32'(modulus) > FERMAT_OFFSET)
            e_full = BASE_W'(modulus) - BASE_W'(FERMAT_OFFSET);
         else
            e_full = '0;
      end else begin
         e_full = {1'b0, req_exponent};
      end
   end

   always_comb begin
      scan_in   = scan_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      pw_in     = pw_ff;
      exp_in    = exp_ff;
      result_in = result_ff;
      if (cmd.load) begin
         scan_in = req_base;
         cnt_in  = CNT_W'(BASE_W);
         r_in    = '0;
         acc_in  = MOD_BITS'(1);
         exp_in  = e_full[EXP_BITS-1:0];
      end
      if (cmd.start_mul) begin
         scan_in = {mul_y, {(BASE_W-MOD_BITS){1'b0}}};
         cnt_in  = CNT_W'(MOD_BITS);
         r_in    = '0;
      end
      if (cmd.step) begin
         scan_in = {scan_ff[BASE_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         r_in    = r_next;
         if (last) begin
            if (cmd.dest == DEST_ACC) acc_in = r_next;
            else pw_in = r_next;
         end
      end
      if (cmd.shift_exp) exp_in = exp_ff >> 1;
      if (cmd.out_load) begin
         result_in = (modulus == '0) ? '0 : RESULT_W'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      r_ff      <= r_in;
      acc_ff    <= acc_in;
      pw_ff     <= pw_in;
      exp_ff    <= exp_in;
      result_ff <= result_in;
   end

   assign status.step_last = last;
   assign status.exp_zero  = (exp_ff == '0);
   assign status.exp_lsb   = exp_ff[0];
   assign status.mod_zero  = (modulus == '0);
   assign rsp_result       = result_ff;

endmodule

@@ rtl/modular_exponentiation_top.sv @@
// Modular exponentiation by right-to-left square-and-multiply.
// Input channel req_*: kind (0 power, 1 Fermat inverse with exponent
// modulus minus two), a 64-bit base and a 63-bit exponent. Result channel
// rsp_*: one 32-bit result per item. Both use valid/stall handshakes.
// The modulus register sits at byte address 0 of the APB port; write it
// only while no item is in flight. Reset loads 1000000007.
// One item is in work at a time. Each item runs a bit-serial base
// reduction, then one squaring for each exponent bit up to the top set
// bit and one multiply into the accumulator for each set bit, all on the
// shared one-bit-per-cycle modular multiplier. A finished result waits in
// the output register while the receiver stalls; the next item is taken
// meanwhile and finishes only once the register is free.
module modular_exponentiation_top #(
   parameter int EXP_BITS = mex_pkg::EXP_BITS_DEF,
   parameter int MOD_BITS = mex_pkg::MOD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [mex_pkg::BASE_W-1:0]      req_base,
   input  logic [mex_pkg::EXP_W-1:0]       req_exponent,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mex_pkg::RESULT_W-1:0]    rsp_result,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mex_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mex_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mex_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import mex_pkg::*;

   logic [MOD_BITS-1:0]  mod_ff, mod_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;
   dp_cmd_type           cmd;
   dp_status_type        status;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign mod_in  = (csr_wr && csr_idx == REG_MODULUS) ? pwdata[MOD_BITS-1:0] : mod_ff;
   assign prdata  = (csr_idx == REG_MODULUS) ? CSR_DATA_W'(mod_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= RESET_MODULUS[MOD_BITS-1:0];
      end else begin
         mod_ff <= mod_in;
      end
   end

   mex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mex_dpath #(
      .EXP_BITS (EXP_BITS),
      .MOD_BITS (MOD_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .modulus      (mod_ff),
      .req_kind     (req_kind),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .cmd          (cmd),
      .status       (status),
      .rsp_result   (rsp_result)
   );

endmodule

@@ tb/testbench.sv @@
module testbench;
   import mex_pkg::*;

   localparam bit KIND_POWER   = 1'b0;
   localparam bit KIND_INVERSE = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int HOLD_AFTER   = 35;
   localparam int HOLD_CYCLES  = 2500;
   localparam int SETTLE_CYCLES = 500;

   typedef struct {
      bit               kind;
      bit [BASE_W-1:0]  base;
      bit [EXP_W-1:0]   exponent;
   } exp_request_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_kind = 1'b0;
   logic [BASE_W-1:0]       req_base = '0;
   logic [EXP_W-1:0]        req_exponent = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [RESULT_W-1:0]     rsp_result;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   paddr = '0;
   logic [CSR_DATA_W-1:0]   pwdata = '0;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   exp_request_type         pending_requests[$];
   bit [RESULT_W-1:0]       expected_powers[$];
   exp_request_type         staged_request;
   bit [RESULT_W-1:0]       wanted_power;
   bit [31:0]               modulus_now = RESET_MODULUS;

   int sender_idle_pct = 13;
   int receiver_idle_pct = 48;
   int items_accepted = 0;
   int inverse_items = 0;
   int results_seen = 0;
   int fail_count = 0;
   int modulus_settings = 1;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int cycle_count = 0;

   modular_exponentiation_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit [RESULT_W-1:0] modpow_expected(bit kind_in, bit [63:0] base_in,
                                                        bit [62:0] exp_in);
      bit [63:0] m;
      bit [63:0] acc;
      bit [63:0] pw;
      bit [63:0] e;
      m = {32'b0, modulus_now};
      if (m == 0)
         return '0;
      e = {1'b0, exp_in};
      if (kind_in == KIND_INVERSE)
         e = (m <= FERMAT_OFFSET) ? 64'd0 : m - FERMAT_OFFSET;
      acc = 64'd1;
      pw = base_in % m;
      while (e != 0) begin
         if (e[0])
            acc = (acc * pw) % m;
         e = e >> 1;
         pw = (pw * pw) % m;
      end
      return acc[RESULT_W-1:0];
   endfunction

   function automatic exp_request_type random_request();
      exp_request_type r;
      bit [63:0] raw;
      bit [63:0] mask;
      int pick;
      int w;
      r.kind = ($urandom_range(99) < 25) ? KIND_INVERSE : KIND_POWER;
      case ($urandom_range(5))
         0: r.base = {$urandom, $urandom};
         1: r.base = 64'($urandom_range(15));
         2: r.base = {32'b0, modulus_now} + 64'($urandom_range(3));
         3: r.base = {32'b0, modulus_now} - 64'd1;
         4: r.base = {32'b0, $urandom};
         default: r.base = '1;
      endcase
      pick = $urandom_range(99);
      if (pick < 75)
         w = $urandom_range(10);
      else if (pick < 93)
         w = $urandom_range(32, 11);
      else
         w = 63;
      raw = {$urandom, $urandom};
      mask = (64'd1 << w) - 64'd1;
      r.exponent = raw[62:0] & mask[62:0];
      return r;
   endfunction

   task automatic queue_request(bit kind_in, bit [63:0] base_in, bit [62:0] exp_in);
      exp_request_type r;
      r.kind = kind_in;
      r.base = base_in;
      r.exponent = exp_in;
      pending_requests = {pending_requests, r};
   endtask

   task automatic queue_random(int count);
      repeat (count) pending_requests = {pending_requests, random_request()};
   endtask

   task automatic drain_results();
      while (pending_requests.size() != 0 || req_valid || expected_powers.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_modulus(bit [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= MODULUS_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      modulus_now = value;
      modulus_settings++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_powers = {expected_powers,
                               modpow_expected(req_kind, req_base, req_exponent)};
            items_accepted++;
            if (req_kind == KIND_INVERSE)
               inverse_items++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               staged_request = pending_requests[0];
               pending_requests.delete(0);
               req_valid    <= 1'b1;
               req_kind     <= staged_request.kind;
               req_base     <= staged_request.base;
               req_exponent <= staged_request.exponent;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_powers.size() == 0) begin
               $display("%0t: unexpected result: expected none, got %0d", $time, rsp_result);
               fail_count++;
            end else begin
               wanted_power = expected_powers[0];
               expected_powers.delete(0);
               if (rsp_result !== wanted_power) begin
                  $display("%0t: result mismatch: expected %0d, got %0d",
                           $time, wanted_power, rsp_result);
                  fail_count++;
               end
            end
         end
         // hold off the receiver once so the block backs up into its input
         if (!hold_done && results_seen == HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0)
            hold_left--;
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_request(KIND_POWER, 64'd0, 63'd0);
      queue_request(KIND_POWER, 64'd0, 63'd5);
      queue_request(KIND_POWER, 64'd2, 63'd10);
      queue_request(KIND_POWER, '1, 63'd1);
      queue_request(KIND_POWER, '1, '1);
      queue_request(KIND_POWER, 64'd1000000007, 63'd3);
      queue_request(KIND_POWER, 64'd3, 63'd1000000006);
      queue_request(KIND_POWER, 64'h1234_5678_9ABC_DEF0, 63'h4000_0000_0000_0000);
      queue_request(KIND_POWER, 64'hDEAD_BEEF_0000_0001, 63'd0);
      queue_request(KIND_INVERSE, 64'd2, 63'd0);
      queue_request(KIND_INVERSE, 64'd0, '1);
      queue_request(KIND_INVERSE, 64'd1000000007, 63'd0);
      queue_random(35);
      drain_results();

      write_modulus(32'hFFFF_FFFF);
      queue_request(KIND_INVERSE, 64'd2, 63'd0);
      queue_random(20);
      drain_results();

      sender_idle_pct = 48;
      receiver_idle_pct = 13;
      write_modulus(32'd4294967291);
      queue_request(KIND_INVERSE, 64'd4294967290, 63'd0);
      queue_request(KIND_POWER, 64'd4294967290, '1);
      queue_request(KIND_POWER, '1, 63'd2);
      queue_random(20);
      drain_results();

      write_modulus(32'd1);
      queue_request(KIND_POWER, 64'd5, 63'd0);
      queue_request(KIND_POWER, 64'd5, 63'd1);
      queue_request(KIND_INVERSE, 64'd7, 63'd0);
      queue_random(2);
      drain_results();

      write_modulus(32'd2);
      queue_request(KIND_POWER, 64'd3, 63'd5);
      queue_request(KIND_INVERSE, 64'd3, 63'd0);
      queue_request(KIND_POWER, 64'd4, 63'd1);
      queue_random(2);
      drain_results();

      write_modulus(32'd3);
      queue_request(KIND_INVERSE, 64'd2, 63'd0);
      queue_request(KIND_INVERSE, 64'd3, 63'd0);
      queue_request(KIND_POWER, 64'd2, 63'd2);
      queue_random(2);
      drain_results();

      write_modulus(32'd0);
      queue_request(KIND_POWER, 64'd0, 63'd0);
      queue_request(KIND_POWER, 64'd5, 63'd3);
      queue_request(KIND_INVERSE, 64'd5, 63'd0);
      queue_random(2);
      drain_results();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_modulus($urandom);
      queue_random(16);
      drain_results();

      write_modulus(32'd65537);
      queue_random(13);
      drain_results();

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d items (%0d inverse) across %0d modulus settings;",
               items_accepted, inverse_items, modulus_settings);
      $display("%0d results checked, %0d mismatches.", results_seen, fail_count);
      if (fail_count == 0 && expected_powers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
